// ----- src/utf8_name_sanitizer_macros.svh -----
// Assertion macros shared by the name sanitizer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef UTF8_NAME_SANITIZER_MACROS_SVH
`define UTF8_NAME_SANITIZER_MACROS_SVH

// Same-cycle implication.
`define U8NS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define U8NS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/u8ns_pkg.sv -----
// Types, constants and helpers for the UTF-8 name sanitizer.
// No dependencies; the module files refer to it by scoped names.
`default_nettype none

package u8ns_pkg;

	localparam int unsigned BYTES_W    = 10;
	localparam int unsigned CHARS_W    = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [BYTES_W-1:0] RST_MAX_BYTES = 10'd360;
	localparam logic [CHARS_W-1:0] RST_MAX_CHARS = 8'd120;

	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] DEL_CHAR   = 8'h7F;
	localparam logic [7:0] ASCII_TOP  = 8'h80;
	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] TAG_CONT   = 8'h80;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] TAG_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] TAG_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] TAG_LEAD4  = 8'hF0;

	localparam int unsigned JOBQ_DEPTH = 4;
	localparam int unsigned JOBQ_AW    = 2;
	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_AW    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BYTES = 1'b0,
		REG_MAX_CHARS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               name_end;
		logic [BYTES_W-1:0] name_bytes;
		logic [CHARS_W-1:0] name_chars;
	} result_t;

	// One unit of work for the back end: a whole character and/or a terminator.
	typedef struct packed {
		logic [2:0]         nbytes;
		logic [3:0][7:0]    bytes;
		logic [BYTES_W-1:0] bytes_base;
		logic [CHARS_W-1:0] chars;
		logic               term;
	} job_t;

	// Sequence length announced by a lead byte, zero if not a lead.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		begin
			len = 3'd0;
			if ((b & MASK_LEAD2) == TAG_LEAD2) begin
				len = 3'd2;
			end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
				len = 3'd3;
			end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
				len = 3'd4;
			end
			return len;
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/u8ns_front.sv -----
// Front end: classifies each byte, tracks the pending character and counts.
// Depends on u8ns_pkg and the assertion macros header.
`default_nettype none
`include "utf8_name_sanitizer_macros.svh"

module u8ns_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire u8ns_pkg::item_t                item,
	input  wire logic [u8ns_pkg::BYTES_W-1:0]   max_bytes,
	input  wire logic [u8ns_pkg::CHARS_W-1:0]   max_chars,
	output      logic                           job_valid,
	output      u8ns_pkg::job_t                 job
);

	logic [7:0]                     lead_q;
	logic [2:0]                     seq_len_q;
	logic [1:0]                     gathered_q;
	logic [7:0]                     cont_q [3];
	logic [u8ns_pkg::BYTES_W-1:0]   bytes_q;
	logic [u8ns_pkg::CHARS_W-1:0]   chars_q;
	logic                           stopped_q;

	logic [7:0]  b;
	logic        is_cont, cont_path, complete, fresh;
	logic [2:0]  fresh_len;
	logic        want_emit, limit_ok, emit_ok, emit_fail, zero_stop;
	logic [2:0]  emit_len;
	logic [3:0][7:0] emit_bytes;
	logic [7:0]  cont_m [3];
	logic [8:0]  chars_inc;
	logic [10:0] bytes_sum;

	assign b         = item.in_byte;
	assign is_cont   = (b & u8ns_pkg::MASK_CONT) == u8ns_pkg::TAG_CONT;
	assign cont_path = !stopped_q && (seq_len_q != 3'd0) && is_cont;
	assign fresh     = !stopped_q && !cont_path;
	assign complete  = cont_path && ((3'(gathered_q) + 3'd2) >= seq_len_q);
	assign fresh_len = u8ns_pkg::lead_len(b);
	assign zero_stop = fresh && (b == 8'd0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cont_m[i] = (gathered_q == 2'(i)) ? b : cont_q[i];
		end
	end

	always_comb begin
		want_emit  = 1'b0;
		emit_len   = 3'd0;
		emit_bytes = '0;
		if (complete) begin
			want_emit  = 1'b1;
			emit_len   = seq_len_q;
			emit_bytes = {cont_m[2], cont_m[1], cont_m[0], lead_q};
		end else if (fresh && b >= u8ns_pkg::CTRL_LIMIT && b < u8ns_pkg::ASCII_TOP
		             && b != u8ns_pkg::DEL_CHAR) begin
			want_emit     = 1'b1;
			emit_len      = 3'd1;
			emit_bytes[0] = b;
		end
	end

	assign chars_inc = 9'(chars_q) + 9'd1;
	assign bytes_sum = 11'(bytes_q) + 11'(emit_len);
	assign limit_ok  = (chars_inc <= 9'(max_chars)) && (bytes_sum <= 11'(max_bytes));
	assign emit_ok   = want_emit && limit_ok;
	assign emit_fail = want_emit && !limit_ok;

	assign job_valid       = accept && (emit_ok || item.last_byte);
	assign job.nbytes      = emit_ok ? emit_len : 3'd0;
	assign job.bytes       = emit_bytes;
	assign job.bytes_base  = bytes_q;
	assign job.chars       = emit_ok ? chars_inc[u8ns_pkg::CHARS_W-1:0] : chars_q;
	assign job.term        = item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= '0;
			seq_len_q  <= '0;
			gathered_q <= '0;
			bytes_q    <= '0;
			chars_q    <= '0;
			stopped_q  <= 1'b0;
		end else if (accept) begin
			if (item.last_byte) begin
				lead_q     <= '0;
				seq_len_q  <= '0;
				gathered_q <= '0;
				bytes_q    <= '0;
				chars_q    <= '0;
				stopped_q  <= 1'b0;
			end else begin
				if (cont_path) begin
					if (complete) begin
						seq_len_q  <= '0;
						gathered_q <= '0;
					end else begin
						gathered_q <= gathered_q + 2'd1;
					end
				end else if (fresh) begin
					gathered_q <= '0;
					if (fresh_len != 3'd0) begin
						lead_q    <= b;
						seq_len_q <= fresh_len;
					end else begin
						seq_len_q <= '0;
					end
				end
				if (emit_ok) begin
					chars_q <= chars_inc[u8ns_pkg::CHARS_W-1:0];
					bytes_q <= bytes_sum[u8ns_pkg::BYTES_W-1:0];
				end
				if (emit_fail || zero_stop) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	// Continuation bytes carry no reset; only entries of the pending character are read.
	always_ff @(posedge clk) begin
		if (accept && cont_path) begin
			cont_q[gathered_q] <= b;
		end
	end

	`U8NS_ASSERT_IMPL(a_pend_bound, seq_len_q != 3'd0, (3'(gathered_q) + 3'd1) < seq_len_q, "pending count past length")
	`U8NS_ASSERT_IMPL(a_stop_clear, stopped_q, seq_len_q == 3'd0, "character pending while stopped")

endmodule

`default_nettype wire

// ----- src/u8ns_jobq.sv -----
// Short job queue between the front and back ends.
// Depends on u8ns_pkg and the assertion macros header.
`default_nettype none
`include "utf8_name_sanitizer_macros.svh"

module u8ns_jobq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u8ns_pkg::job_t  wdata,
	output      logic            full,
	input  wire logic            pop,
	output      logic            valid,
	output      u8ns_pkg::job_t  rdata
);

	localparam int unsigned CNT_W = u8ns_pkg::JOBQ_AW + 1;

	u8ns_pkg::job_t                  mem_q [u8ns_pkg::JOBQ_DEPTH];
	logic [u8ns_pkg::JOBQ_AW-1:0]    wr_q, rd_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            do_push, do_pop;

	assign full    = cnt_q == CNT_W'(u8ns_pkg::JOBQ_DEPTH);
	assign valid   = cnt_q != '0;
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`U8NS_ASSERT_NEXT(a_jobq_grow, push && !full && !pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1), "job count did not grow")

endmodule

`default_nettype wire

// ----- src/u8ns_back.sv -----
// Back end: expands jobs into result requests and buffers them for the consumer.
// Depends on u8ns_pkg and the assertion macros header.
`default_nettype none
`include "utf8_name_sanitizer_macros.svh"

module u8ns_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire u8ns_pkg::job_t     job,
	output      logic               job_pop,
	input  wire logic               pop,
	output      logic               empty,
	output      u8ns_pkg::result_t  result
);

	localparam int unsigned CNT_W = u8ns_pkg::OUTQ_AW + 1;

	logic [2:0]                     idx_q;
	logic [2:0]                     total, idx_plus;
	logic                           step, last_step, outq_full, do_pop;
	u8ns_pkg::result_t              res_d;
	u8ns_pkg::result_t              mem_q [u8ns_pkg::OUTQ_DEPTH];
	logic [u8ns_pkg::OUTQ_AW-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]               cnt_q;

	assign total     = job.nbytes + 3'(job.term);
	assign outq_full = cnt_q == CNT_W'(u8ns_pkg::OUTQ_DEPTH);
	assign step      = job_valid && !outq_full;
	assign last_step = (idx_q + 3'd1) == total;
	assign job_pop   = step && last_step;
	assign idx_plus  = (idx_q < job.nbytes) ? idx_q + 3'd1 : job.nbytes;

	// Character bytes first, terminator last.
	always_comb begin
		res_d.name_bytes = job.bytes_base + u8ns_pkg::BYTES_W'(idx_plus);
		res_d.name_chars = job.chars;
		if (idx_q < job.nbytes) begin
			res_d.out_byte = job.bytes[idx_q[1:0]];
			res_d.name_end = 1'b0;
		end else begin
			res_d.out_byte = 8'd0;
			res_d.name_end = 1'b1;
		end
	end

	assign empty  = cnt_q == '0;
	assign do_pop = pop && !empty;
	assign result = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (step) begin
				idx_q <= last_step ? 3'd0 : idx_q + 3'd1;
				wr_q  <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(step) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mem_q[wr_q] <= res_d;
		end
	end

	`U8NS_ASSERT_IMPL(a_idx_in_job, idx_q != 3'd0, job_valid && (idx_q < total), "expansion index outside job")
	`U8NS_ASSERT_IMPL(a_outq_bound, 1'b1, cnt_q <= CNT_W'(u8ns_pkg::OUTQ_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

// ----- src/utf8_name_sanitizer.sv -----
// Top level of the UTF-8 name sanitizer: limit registers, front end, job queue, back end.
// Depends on u8ns_pkg, u8ns_front, u8ns_jobq and u8ns_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   bytes in | push / full         | item   (in_byte, last_byte)
//   results  | empty / pop         | result (out_byte, name_end, name_bytes, name_chars)
//   config   | cfg_we              | cfg_idx, cfg_data (0: max bytes, 1: max chars)
//
// One byte is accepted per cycle while the job queue is not full; the front end
// classifies it and updates the per-name state in that same cycle. The back end
// writes one result per cycle into a four-deep result queue while it has room,
// so the last byte of a 4-byte character that also closes the name yields five
// results; the job queue (four entries) absorbs these bursts. full rises only
// while the job queue holds four jobs. Results pass the job and then the result queue.
// arst_n clears all control state and loads the limit reset values (360, 120).
`default_nettype none

module utf8_name_sanitizer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output      logic                              full,
	input  wire u8ns_pkg::item_t                   item,
	output      logic                              empty,
	input  wire logic                              pop,
	output      u8ns_pkg::result_t                 result,
	input  wire logic                              cfg_we,
	input  wire logic [u8ns_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [u8ns_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [u8ns_pkg::BYTES_W-1:0] max_bytes_q;
	logic [u8ns_pkg::CHARS_W-1:0] max_chars_q;

	logic            accept;
	logic            fe_job_valid, jq_valid, jq_pop;
	u8ns_pkg::job_t  fe_job, jq_job;

	// Limit registers; the current value applies at each check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= u8ns_pkg::RST_MAX_BYTES;
			max_chars_q <= u8ns_pkg::RST_MAX_CHARS;
		end else if (cfg_we) begin
			unique case (u8ns_pkg::cfg_reg_t'(cfg_idx))
				u8ns_pkg::REG_MAX_BYTES: max_bytes_q <= cfg_data[u8ns_pkg::BYTES_W-1:0];
				u8ns_pkg::REG_MAX_CHARS: max_chars_q <= cfg_data[u8ns_pkg::CHARS_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a request whenever the job queue has room.
	assign accept = push && !full;

	u8ns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.max_bytes (max_bytes_q),
		.max_chars (max_chars_q),
		.job_valid (fe_job_valid),
		.job       (fe_job)
	);

	// Hold jobs here so the front keeps taking bytes while results drain.
	u8ns_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_job_valid),
		.wdata  (fe_job),
		.full   (full),
		.pop    (jq_pop),
		.valid  (jq_valid),
		.rdata  (jq_job)
	);

	// Advance one result per cycle out of the head job while the result queue has room.
	u8ns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (jq_valid),
		.job       (jq_job),
		.job_pop   (jq_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire
